@@ rtl/core/rvdec_pkg.sv @@
package rvdec_pkg;

	// major opcodes
	localparam logic [6:0] OPC_LOAD      = 7'h03;
	localparam logic [6:0] OPC_MISC_MEM  = 7'h0F;
	localparam logic [6:0] OPC_OP_IMM    = 7'h13;
	localparam logic [6:0] OPC_AUIPC     = 7'h17;
	localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
	localparam logic [6:0] OPC_STORE     = 7'h23;
	localparam logic [6:0] OPC_AMO       = 7'h2F;
	localparam logic [6:0] OPC_OP        = 7'h33;
	localparam logic [6:0] OPC_LUI       = 7'h37;
	localparam logic [6:0] OPC_OP_32     = 7'h3B;
	localparam logic [6:0] OPC_BRANCH    = 7'h63;
	localparam logic [6:0] OPC_JALR      = 7'h67;
	localparam logic [6:0] OPC_JAL       = 7'h6F;
	localparam logic [6:0] OPC_SYSTEM    = 7'h73;

	// funct7 values
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT = 7'h20;

	// SYSTEM immediates with funct3 = 0
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;
	localparam logic [11:0] SYS_SRET   = 12'h102;
	localparam logic [11:0] SYS_MRET   = 12'h302;
	localparam logic [11:0] SYS_WFI    = 12'h105;

	// AMO funct5 values
	localparam logic [4:0] AMO_ADD  = 5'h00;
	localparam logic [4:0] AMO_SWAP = 5'h01;
	localparam logic [4:0] AMO_LR   = 5'h02;
	localparam logic [4:0] AMO_SC   = 5'h03;
	localparam logic [4:0] AMO_XOR  = 5'h04;
	localparam logic [4:0] AMO_OR   = 5'h08;
	localparam logic [4:0] AMO_AND  = 5'h0C;
	localparam logic [4:0] AMO_MIN  = 5'h10;
	localparam logic [4:0] AMO_MAX  = 5'h14;
	localparam logic [4:0] AMO_MINU = 5'h18;
	localparam logic [4:0] AMO_MAXU = 5'h1C;

	// format class, decoded from the opcode
	typedef enum logic [3:0] {
		CLS_NONE, CLS_OP, CLS_OP_32, CLS_AMO, CLS_OP_IMM, CLS_OP_IMM_32, CLS_LOAD,
		CLS_JALR, CLS_MISC_MEM, CLS_SYSTEM, CLS_STORE, CLS_BRANCH, CLS_LUI,
		CLS_AUIPC, CLS_JAL
	} cls_t;

	typedef enum logic [6:0] {
		K_INVALID = 7'd0,
		K_LUI, K_AUIPC, K_JAL, K_JALR, K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
		K_LB, K_LH, K_LW, K_LD, K_LBU, K_LHU, K_LWU, K_SB, K_SH, K_SW, K_SD,
		K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
		K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
		K_ADDIW, K_SLLIW, K_SRLIW, K_SRAIW, K_ADDW, K_SUBW, K_SLLW, K_SRLW,
		K_SRAW, K_FENCE, K_FENCE_I, K_ECALL, K_EBREAK, K_CSRRW, K_CSRRS,
		K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI, K_MUL, K_MULH, K_MULHSU,
		K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU, K_MULW, K_DIVW, K_DIVUW,
		K_REMW, K_REMUW, K_LR_W, K_LR_D, K_SC_W, K_SC_D, K_AMOSWAP_W,
		K_AMOSWAP_D, K_AMOADD_W, K_AMOADD_D, K_AMOXOR_W, K_AMOXOR_D,
		K_AMOAND_W, K_AMOAND_D, K_AMOOR_W, K_AMOOR_D, K_AMOMIN_W, K_AMOMIN_D,
		K_AMOMAX_W, K_AMOMAX_D, K_AMOMINU_W, K_AMOMINU_D, K_AMOMAXU_W,
		K_AMOMAXU_D, K_SRET, K_MRET, K_WFI
	} kind_t;

	function automatic cls_t opc_class(input logic [6:0] opc);
		cls_t c;
		unique case (opc)
			OPC_OP:        c = CLS_OP;
			OPC_OP_32:     c = CLS_OP_32;
			OPC_AMO:       c = CLS_AMO;
			OPC_OP_IMM:    c = CLS_OP_IMM;
			OPC_OP_IMM_32: c = CLS_OP_IMM_32;
			OPC_LOAD:      c = CLS_LOAD;
			OPC_JALR:      c = CLS_JALR;
			OPC_MISC_MEM:  c = CLS_MISC_MEM;
			OPC_SYSTEM:    c = CLS_SYSTEM;
			OPC_STORE:     c = CLS_STORE;
			OPC_BRANCH:    c = CLS_BRANCH;
			OPC_LUI:       c = CLS_LUI;
			OPC_AUIPC:     c = CLS_AUIPC;
			OPC_JAL:       c = CLS_JAL;
			default:       c = CLS_NONE;
		endcase
		return c;
	endfunction

	function automatic kind_t kind_op(input logic [2:0] f3, input logic [6:0] f7);
		kind_t k;
		k = K_INVALID;
		if (f7 == F7_BASE) begin
			unique case (f3)
				3'd0: k = K_ADD;
				3'd1: k = K_SLL;
				3'd2: k = K_SLT;
				3'd3: k = K_SLTU;
				3'd4: k = K_XOR;
				3'd5: k = K_SRL;
				3'd6: k = K_OR;
				default: k = K_AND;
			endcase
		end else if (f7 == F7_MULDIV) begin
			unique case (f3)
				3'd0: k = K_MUL;
				3'd1: k = K_MULH;
				3'd2: k = K_MULHSU;
				3'd3: k = K_MULHU;
				3'd4: k = K_DIV;
				3'd5: k = K_DIVU;
				3'd6: k = K_REM;
				default: k = K_REMU;
			endcase
		end else if (f7 == F7_ALT) begin
			if (f3 == 3'd0) k = K_SUB;
			else if (f3 == 3'd5) k = K_SRA;
		end
		return k;
	endfunction

	function automatic kind_t kind_op32(input logic [2:0] f3, input logic [6:0] f7);
		kind_t k;
		k = K_INVALID;
		if (f7 == F7_BASE) begin
			unique case (f3)
				3'd0: k = K_ADDW;
				3'd1: k = K_SLLW;
				3'd5: k = K_SRLW;
				default: k = K_INVALID;
			endcase
		end else if (f7 == F7_MULDIV) begin
			unique case (f3)
				3'd0: k = K_MULW;
				3'd4: k = K_DIVW;
				3'd5: k = K_DIVUW;
				3'd6: k = K_REMW;
				3'd7: k = K_REMUW;
				default: k = K_INVALID;
			endcase
		end else if (f7 == F7_ALT) begin
			if (f3 == 3'd0) k = K_SUBW;
			else if (f3 == 3'd5) k = K_SRAW;
		end
		return k;
	endfunction

	// word form per funct5; doubleword form is the next code
	function automatic kind_t kind_amo(input logic [2:0] f3, input logic [4:0] f5,
			input logic [4:0] rs2);
		kind_t k;
		logic  dbl;
		dbl = (f3 == 3'd3);
		unique case (f5)
			AMO_ADD:  k = dbl ? K_AMOADD_D : K_AMOADD_W;
			AMO_SWAP: k = dbl ? K_AMOSWAP_D : K_AMOSWAP_W;
			AMO_LR:   k = (rs2 != 5'd0) ? K_INVALID : (dbl ? K_LR_D : K_LR_W);
			AMO_SC:   k = dbl ? K_SC_D : K_SC_W;
			AMO_XOR:  k = dbl ? K_AMOXOR_D : K_AMOXOR_W;
			AMO_OR:   k = dbl ? K_AMOOR_D : K_AMOOR_W;
			AMO_AND:  k = dbl ? K_AMOAND_D : K_AMOAND_W;
			AMO_MIN:  k = dbl ? K_AMOMIN_D : K_AMOMIN_W;
			AMO_MAX:  k = dbl ? K_AMOMAX_D : K_AMOMAX_W;
			AMO_MINU: k = dbl ? K_AMOMINU_D : K_AMOMINU_W;
			AMO_MAXU: k = dbl ? K_AMOMAXU_D : K_AMOMAXU_W;
			default:  k = K_INVALID;
		endcase
		if (f3 != 3'd2 && f3 != 3'd3) k = K_INVALID;
		return k;
	endfunction

	function automatic kind_t kind_op_imm(input logic [2:0] f3, input logic alt);
		kind_t k;
		unique case (f3)
			3'd0: k = K_ADDI;
			3'd1: k = K_SLLI;
			3'd2: k = K_SLTI;
			3'd3: k = K_SLTIU;
			3'd4: k = K_XORI;
			3'd5: k = alt ? K_SRAI : K_SRLI;
			3'd6: k = K_ORI;
			default: k = K_ANDI;
		endcase
		return k;
	endfunction

	function automatic kind_t kind_load(input logic [2:0] f3);
		kind_t k;
		unique case (f3)
			3'd0: k = K_LB;
			3'd1: k = K_LH;
			3'd2: k = K_LW;
			3'd3: k = K_LD;
			3'd4: k = K_LBU;
			3'd5: k = K_LHU;
			3'd6: k = K_LWU;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic kind_t kind_branch(input logic [2:0] f3);
		kind_t k;
		unique case (f3)
			3'd0: k = K_BEQ;
			3'd1: k = K_BNE;
			3'd4: k = K_BLT;
			3'd5: k = K_BGE;
			3'd6: k = K_BLTU;
			3'd7: k = K_BGEU;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic kind_t kind_store(input logic [2:0] f3);
		kind_t k;
		unique case (f3)
			3'd0: k = K_SB;
			3'd1: k = K_SH;
			3'd2: k = K_SW;
			3'd3: k = K_SD;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic kind_t kind_csr(input logic [2:0] f3);
		kind_t k;
		unique case (f3)
			3'd1: k = K_CSRRW;
			3'd2: k = K_CSRRS;
			3'd3: k = K_CSRRC;
			3'd5: k = K_CSRRWI;
			3'd6: k = K_CSRRSI;
			3'd7: k = K_CSRRCI;
			default: k = K_INVALID;
		endcase
		return k;
	endfunction

	function automatic kind_t kind_sys(input logic [11:0] imm12);
		kind_t k;
		unique case (imm12)
			SYS_ECALL:  k = K_ECALL;
			SYS_EBREAK: k = K_EBREAK;
			SYS_SRET:   k = K_SRET;
			SYS_MRET:   k = K_MRET;
			SYS_WFI:    k = K_WFI;
			default:    k = K_INVALID;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/core/rv64ima_instruction_decoder.sv @@
// RV64IMA instruction decoder, three register stages.
// A word taken with start passes the stage 1, stage 2 and output registers and shows
//   on the result ports with done, for exactly one cycle.
// Throughput: one word per cycle; busy is held low since the receiver cannot stall.
// Reset: arst_n clears the stage valid bits (and done) asynchronously; the
//   payload registers are not reset.
module rv64ima_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        instr_word,
	output logic               done,
	output logic [6:0]         instr_kind,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic signed [31:0] immediate
);
	import rvdec_pkg::*;

	// Stage 1: capture the word and classify its opcode.
	logic        vld_s1;
	logic [31:0] word_s1;
	cls_t        cls_s1;

	// Stage 2: kind, register numbers and immediate per format.
	logic        vld_s2;
	kind_t       kind_s2;
	logic [4:0]  rd_s2, rs1_s2, rs2_s2;
	logic [31:0] imm_s2;

	// Stage 2 combinational decode.
	kind_t       kind_c;
	logic [4:0]  rd_c, rs1_c, rs2_c;
	logic [31:0] imm_c;

	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [11:0] imm12;
	logic [31:0] sext12;

	// Nothing downstream ever pushes back, so the block always takes a word.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= instr_word;
		cls_s1  <= opc_class(instr_word[6:0]);
	end

	assign f3     = word_s1[14:12];
	assign f7     = word_s1[31:25];
	assign imm12  = word_s1[31:20];
	assign sext12 = {{20{imm12[11]}}, imm12};

	always_comb begin
		kind_c = K_INVALID;
		rd_c   = 5'd0;
		rs1_c  = 5'd0;
		rs2_c  = 5'd0;
		imm_c  = 32'd0;
		unique case (cls_s1)
			CLS_OP, CLS_OP_32, CLS_AMO: begin
				if (cls_s1 == CLS_OP) kind_c = kind_op(f3, f7);
				else if (cls_s1 == CLS_OP_32) kind_c = kind_op32(f3, f7);
				else kind_c = kind_amo(f3, f7[6:2], word_s1[24:20]);
				rd_c  = word_s1[11:7];
				rs1_c = word_s1[19:15];
				rs2_c = word_s1[24:20];
			end
			CLS_OP_IMM: begin
				kind_c = kind_op_imm(f3, word_s1[30]);
				rd_c   = word_s1[11:7];
				rs1_c  = word_s1[19:15];
				// shift amounts come through raw, shift-type bits included
				imm_c  = (f3 == 3'd1 || f3 == 3'd5) ? {20'd0, imm12} : sext12;
			end
			CLS_OP_IMM_32: begin
				rd_c  = word_s1[11:7];
				rs1_c = word_s1[19:15];
				case (f3)
					3'd0: begin
						kind_c = K_ADDIW;
						imm_c  = sext12;
					end
					3'd1: begin
						kind_c = K_SLLIW;
						imm_c  = {20'd0, imm12};
					end
					3'd5: begin
						kind_c = word_s1[30] ? K_SRAIW : K_SRLIW;
						imm_c  = {20'd0, imm12};
					end
					default: kind_c = K_INVALID;
				endcase
			end
			CLS_LOAD, CLS_JALR: begin
				kind_c = (cls_s1 == CLS_LOAD) ? kind_load(f3) : K_JALR;
				rd_c   = word_s1[11:7];
				rs1_c  = word_s1[19:15];
				imm_c  = sext12;
			end
			CLS_MISC_MEM: begin
				if (f3 == 3'd0) kind_c = K_FENCE;
				else if (f3 == 3'd1) kind_c = K_FENCE_I;
				rd_c  = word_s1[11:7];
				rs1_c = word_s1[19:15];
				imm_c = sext12;
			end
			CLS_SYSTEM: begin
				if (f3 != 3'd0) begin
					// CSR forms: rs1 field doubles as uimm, CSR number raw
					kind_c = kind_csr(f3);
					rd_c   = word_s1[11:7];
					rs1_c  = word_s1[19:15];
					imm_c  = {20'd0, imm12};
				end else begin
					kind_c = kind_sys(imm12);
				end
			end
			CLS_STORE: begin
				kind_c = kind_store(f3);
				rs1_c  = word_s1[19:15];
				rs2_c  = word_s1[24:20];
				imm_c  = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
			end
			CLS_BRANCH: begin
				kind_c = kind_branch(f3);
				rs1_c  = word_s1[19:15];
				rs2_c  = word_s1[24:20];
				imm_c  = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
					word_s1[11:8], 1'b0};
			end
			CLS_LUI, CLS_AUIPC: begin
				kind_c = (cls_s1 == CLS_LUI) ? K_LUI : K_AUIPC;
				rd_c   = word_s1[11:7];
				imm_c  = {word_s1[31:12], 12'd0};
			end
			CLS_JAL: begin
				kind_c = K_JAL;
				rd_c   = word_s1[11:7];
				imm_c  = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
					word_s1[30:21], 1'b0};
			end
			default: kind_c = K_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_c;
		rd_s2   <= rd_c;
		rs1_s2  <= rs1_c;
		rs2_s2  <= rs2_c;
		imm_s2  <= imm_c;
	end

	// Stage 3: an invalid word reports all-zero fields.
	logic inv_s2;
	assign inv_s2 = (kind_s2 == K_INVALID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		instr_kind <= kind_s2;
		dest_reg   <= inv_s2 ? 5'd0 : rd_s2;
		src1_reg   <= inv_s2 ? 5'd0 : rs1_s2;
		src2_reg   <= inv_s2 ? 5'd0 : rs2_s2;
		immediate  <= inv_s2 ? 32'sd0 : $signed(imm_s2);
	end

	// Every accepted word comes out with done, through the stage 1, stage 2 and output registers.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word did not produce a result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##3 !done)
		else $error("result without an accepted word");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && instr_kind == K_INVALID) |->
		(dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0 && immediate == 32'sd0))
		else $error("invalid word with nonzero fields");

	a_upper_imm: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (instr_kind == K_LUI || instr_kind == K_AUIPC)) |->
		(immediate[11:0] == 12'd0 && src1_reg == 5'd0 && src2_reg == 5'd0))
		else $error("U-type result malformed");

endmodule
